// ----- sv/alm_pkg.sv -----
package alm_pkg;

  localparam int unsigned PointW  = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned BandW   = 31;
  localparam int unsigned CmpW    = ValW + 2;
  localparam int unsigned MaxMsg  = 6;
  localparam int unsigned MsgCntW = 3;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCntW   = 3;
  localparam int unsigned RegIdxW = 3;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_HIGH_HIGH = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HIGH      = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LOW       = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LOW_LOW   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HIGH_HYST = 3'd4;
  localparam logic [RegIdxW-1:0] REG_LOW_HYST  = 3'd5;
  localparam logic [RegIdxW-1:0] REG_DEAD_BAND = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SCAN_EN   = 3'd7;

  // message kinds
  localparam logic [1:0] KIND_FAULT  = 2'd0;
  localparam logic [1:0] KIND_FORCE  = 2'd1;
  localparam logic [1:0] KIND_NORMAL = 2'd2;
  localparam logic [1:0] KIND_LIMIT  = 2'd3;

  // stored limit state
  localparam logic [2:0] LS_NORMAL   = 3'd0;
  localparam logic [2:0] LS_HI_WARN  = 3'd1;
  localparam logic [2:0] LS_HI_ALARM = 3'd2;
  localparam logic [2:0] LS_LO_WARN  = 3'd3;
  localparam logic [2:0] LS_LO_ALARM = 3'd4;

  // event states carried in messages
  localparam logic [3:0] EST_NORMAL   = 4'd0;
  localparam logic [3:0] EST_HI_WARN  = 4'd1;
  localparam logic [3:0] EST_HI_ALARM = 4'd2;
  localparam logic [3:0] EST_LO_WARN  = 4'd3;
  localparam logic [3:0] EST_LO_ALARM = 4'd4;
  localparam logic [3:0] EST_HI_REC   = 4'd5;
  localparam logic [3:0] EST_HH_REC   = 4'd6;
  localparam logic [3:0] EST_LO_REC   = 4'd7;
  localparam logic [3:0] EST_LL_REC   = 4'd8;

  typedef logic [5:0] evcode_t;  // {kind, state}

  typedef struct packed {
    logic [MsgCntW-1:0]        n;
    evcode_t [MaxMsg-1:0]      code;
  } evlist_t;

  typedef struct packed {
    logic [PointW-1:0] point;
    logic [ValW-1:0]   data;
    logic              fail;
    logic              frc;
    logic              ovf;
    evlist_t           ev;
  } rec_t;

  function automatic evlist_t ev_add(evlist_t l, logic [1:0] kind, logic [3:0] st);
    evlist_t r;
    r = l;
    if (l.n < MsgCntW'(MaxMsg)) begin
      r.code[l.n] = {kind, st};
      r.n = l.n + 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/alm_front.sv -----
module alm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [alm_pkg::PointW-1:0]        point_num,
  input  logic signed [alm_pkg::ValW-1:0]   value_milli,
  input  logic signed [alm_pkg::ValW-1:0]   reference_milli,
  input  logic                              chan_fault,
  input  logic                              forced,
  input  logic                              out_of_range,
  input  logic                              wr_en,
  input  logic [alm_pkg::RegIdxW-1:0]       wr_index,
  input  logic [alm_pkg::ValW-1:0]          wr_data,
  output logic                              q_push,
  input  logic                              q_full,
  output alm_pkg::rec_t                     q_rec
);

  typedef struct packed {
    logic gt_hh;
    logic gt_h;
    logic ge_l;
    logic ge_ll;
    logic gt_hhb;
    logic gt_hb;
    logic lt_lb;
    logic lt_llb;
    logic vary;
  } cmp_t;

  // configuration
  logic [alm_pkg::ValW-1:0]  hh_lim, h_lim, l_lim, ll_lim;
  logic [alm_pkg::BandW-1:0] hi_hyst, lo_hyst, dead_band;
  logic                      scan_en;

  // stage A
  logic                       a_v;
  logic [alm_pkg::PointW-1:0] a_point;
  logic [alm_pkg::ValW-1:0]   a_data;
  logic                       a_fault, a_force, a_ovf;
  cmp_t                       a_cmp;

  // scan state
  logic       prev_fault, prev_force, prev_ovf, unprimed;
  logic [2:0] limit_state, limit_state_next;

  cmp_t                               cmp;
  logic signed [alm_pkg::CmpW-1:0]    v, r, hh, h, l, ll, hhy, lhy, db, d;
  alm_pkg::evlist_t                   ev;
  logic [2:0]                         st, old, nst;
  logic [1:0]                         pre;
  logic                               done;
  logic                               accept, advance;

  function automatic logic signed [alm_pkg::CmpW-1:0] sx(logic [alm_pkg::ValW-1:0] x);
    return {{(alm_pkg::CmpW - alm_pkg::ValW){x[alm_pkg::ValW-1]}}, x};
  endfunction

  function automatic logic [2:0] classify(cmp_t c);
    logic [2:0] res;
    if (c.gt_hh)      res = alm_pkg::LS_HI_ALARM;
    else if (c.gt_h)  res = alm_pkg::LS_HI_WARN;
    else if (c.ge_l)  res = alm_pkg::LS_NORMAL;
    else if (c.ge_ll) res = alm_pkg::LS_LO_WARN;
    else              res = alm_pkg::LS_LO_ALARM;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      hh_lim    <= {1'b0, {(alm_pkg::ValW-1){1'b1}}};
      h_lim     <= {1'b0, {(alm_pkg::ValW-1){1'b1}}};
      l_lim     <= {1'b1, {(alm_pkg::ValW-1){1'b0}}};
      ll_lim    <= {1'b1, {(alm_pkg::ValW-1){1'b0}}};
      hi_hyst   <= '0;
      lo_hyst   <= '0;
      dead_band <= '0;
      scan_en   <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        alm_pkg::REG_HIGH_HIGH: hh_lim    <= wr_data;
        alm_pkg::REG_HIGH:      h_lim     <= wr_data;
        alm_pkg::REG_LOW:       l_lim     <= wr_data;
        alm_pkg::REG_LOW_LOW:   ll_lim    <= wr_data;
        alm_pkg::REG_HIGH_HYST: hi_hyst   <= wr_data[alm_pkg::BandW-1:0];
        alm_pkg::REG_LOW_HYST:  lo_hyst   <= wr_data[alm_pkg::BandW-1:0];
        alm_pkg::REG_DEAD_BAND: dead_band <= wr_data[alm_pkg::BandW-1:0];
        alm_pkg::REG_SCAN_EN:   scan_en   <= wr_data[0];
        default: ;
      endcase
    end
  end

  // limit and dead band compares, all in parallel
  always_comb begin
    v   = sx(value_milli);
    r   = sx(reference_milli);
    hh  = sx(hh_lim);
    h   = sx(h_lim);
    l   = sx(l_lim);
    ll  = sx(ll_lim);
    hhy = {3'b000, hi_hyst};
    lhy = {3'b000, lo_hyst};
    db  = {3'b000, dead_band};
    d   = v - r;
    cmp.gt_hh  = v > hh;
    cmp.gt_h   = v > h;
    cmp.ge_l   = v >= l;
    cmp.ge_ll  = v >= ll;
    cmp.gt_hhb = v > (hh - hhy);
    cmp.gt_hb  = v > (h - hhy);
    cmp.lt_lb  = v < (l + lhy);
    cmp.lt_llb = v < (ll + lhy);
    // d nonzero and |d| >= db, without forming the absolute value
    cmp.vary   = (d != '0) && ((d >= db) || ((d + db) <= 0));
  end

  assign advance = a_v && (!scan_en || unprimed || ev.n == '0 || !q_full);
  assign full    = a_v && !advance;
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (accept) begin
      a_v <= 1'b1;
    end else if (advance) begin
      a_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_point <= point_num;
      a_data  <= value_milli;
      a_fault <= chan_fault;
      a_force <= forced;
      a_ovf   <= out_of_range & ~chan_fault;
      a_cmp   <= cmp;
    end
  end

  // event generation from the stored state
  always_comb begin
    ev   = '0;
    st   = limit_state;
    old  = alm_pkg::LS_NORMAL;
    nst  = alm_pkg::LS_NORMAL;
    pre  = 2'd0;
    done = 1'b0;
    if (st > alm_pkg::LS_LO_ALARM) st = alm_pkg::LS_NORMAL;
    if (unprimed) begin
      limit_state_next = a_ovf ? alm_pkg::LS_NORMAL : classify(a_cmp);
    end else begin
      if (a_fault != prev_fault)
        ev = alm_pkg::ev_add(ev, alm_pkg::KIND_FAULT, {3'b000, a_fault});
      if (a_force != prev_force)
        ev = alm_pkg::ev_add(ev, alm_pkg::KIND_FORCE, {3'b000, a_force});
      if (!a_fault && a_ovf != prev_ovf) begin
        ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_NORMAL);
        if (!a_ovf) st = alm_pkg::LS_NORMAL;
      end
      if (a_fault && prev_fault && a_cmp.vary)
        ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_NORMAL);
      if (a_cmp.vary && !a_fault && !a_ovf) begin
        old = prev_fault ? alm_pkg::LS_NORMAL : st;
        case (old)
          alm_pkg::LS_HI_WARN: begin
            if (a_cmp.gt_hh) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_ALARM);
              nst = alm_pkg::LS_HI_ALARM; done = 1'b1;
            end else if (a_cmp.gt_hb) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_HI_WARN);
              nst = alm_pkg::LS_HI_WARN; done = 1'b1;
            end else begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_REC);
              pre = 2'd1;
            end
          end
          alm_pkg::LS_HI_ALARM: begin
            if (a_cmp.gt_hhb) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_HI_ALARM);
              nst = alm_pkg::LS_HI_ALARM; done = 1'b1;
            end else begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HH_REC);
              if (a_cmp.gt_hb) begin
                nst = alm_pkg::LS_HI_WARN; done = 1'b1;
              end else begin
                ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_REC);
                pre = 2'd1;
              end
            end
          end
          alm_pkg::LS_LO_WARN: begin
            if (!a_cmp.ge_ll) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_ALARM);
              nst = alm_pkg::LS_LO_ALARM; done = 1'b1;
            end else if (a_cmp.lt_lb) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_LO_WARN);
              nst = alm_pkg::LS_LO_WARN; done = 1'b1;
            end else begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_REC);
              pre = 2'd2;
            end
          end
          alm_pkg::LS_LO_ALARM: begin
            if (a_cmp.lt_llb) begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_LO_ALARM);
              nst = alm_pkg::LS_LO_ALARM; done = 1'b1;
            end else begin
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LL_REC);
              if (a_cmp.lt_lb) begin
                nst = alm_pkg::LS_LO_WARN; done = 1'b1;
              end else begin
                ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_REC);
                pre = 2'd2;
              end
            end
          end
          default: ;
        endcase
        // leaving from normal, or after a recovery
        if (!done) begin
          if (a_cmp.gt_hh) begin
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_WARN);
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_ALARM);
            nst = alm_pkg::LS_HI_ALARM;
          end else if (a_cmp.gt_h) begin
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_HI_WARN);
            nst = alm_pkg::LS_HI_WARN;
          end else if (a_cmp.ge_l) begin
            if (pre == 2'd0)
              ev = alm_pkg::ev_add(ev, alm_pkg::KIND_NORMAL, alm_pkg::EST_NORMAL);
            nst = alm_pkg::LS_NORMAL;
          end else if (a_cmp.ge_ll) begin
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_WARN);
            nst = alm_pkg::LS_LO_WARN;
          end else begin
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_WARN);
            ev = alm_pkg::ev_add(ev, alm_pkg::KIND_LIMIT, alm_pkg::EST_LO_ALARM);
            nst = alm_pkg::LS_LO_ALARM;
          end
        end
        st = nst;
      end
      if (a_ovf) st = alm_pkg::LS_NORMAL;
      limit_state_next = st;
    end
  end

  assign q_push      = a_v && scan_en && !unprimed && ev.n != '0 && !q_full;
  assign q_rec.point = a_point;
  assign q_rec.data  = a_data;
  assign q_rec.fail  = a_fault;
  assign q_rec.frc   = a_force;
  assign q_rec.ovf   = a_ovf;
  assign q_rec.ev    = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_fault  <= 1'b0;
      prev_force  <= 1'b0;
      prev_ovf    <= 1'b0;
      limit_state <= alm_pkg::LS_NORMAL;
      unprimed    <= 1'b1;
    end else if (advance && scan_en) begin
      prev_fault  <= a_fault;
      prev_force  <= a_force;
      prev_ovf    <= a_ovf;
      limit_state <= limit_state_next;
      unprimed    <= 1'b0;
    end
  end

endmodule

// ----- sv/alm_queue.sv -----
module alm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  alm_pkg::rec_t din,
  input  logic          pop,
  output logic          empty,
  output alm_pkg::rec_t dout
);

  alm_pkg::rec_t                 mem [alm_pkg::QDepth];
  logic [alm_pkg::QPtrW-1:0]     wr_ptr, rd_ptr;
  logic [alm_pkg::QCntW-1:0]     count;
  logic                          do_push, do_pop;

  assign full    = count == alm_pkg::QCntW'(alm_pkg::QDepth);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= alm_pkg::QCntW'(alm_pkg::QDepth))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("scan record pushed into full queue");

endmodule

// ----- sv/alm_back.sv -----
module alm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  alm_pkg::rec_t               q_rec,
  output logic                        empty,
  input  logic                        pop,
  output logic [alm_pkg::PointW-1:0]  point_out,
  output logic signed [alm_pkg::ValW-1:0] data_milli,
  output logic [1:0]                  event_kind,
  output logic [3:0]                  event_state,
  output logic                        to_alarm_list,
  output logic                        status_fail,
  output logic                        status_force,
  output logic                        status_overflow,
  output logic                        last_message
);

  alm_pkg::rec_t               cur;
  logic                        cur_valid;
  logic [alm_pkg::MsgCntW-1:0] idx;
  logic                        out_valid;
  logic                        load_out, last, cur_take;
  alm_pkg::evcode_t            code;

  assign code     = cur.ev.code[idx];
  assign last     = idx == (cur.ev.n - 1'b1);
  assign load_out = cur_valid && (!out_valid || pop);
  assign cur_take = !cur_valid || (load_out && last);
  assign q_pop    = cur_take && !q_empty;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= load_out || (out_valid && !pop);
      if (cur_take) begin
        cur_valid <= !q_empty;
        idx       <= '0;
      end else if (load_out) begin
        idx       <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_take && !q_empty) cur <= q_rec;
    if (load_out) begin
      point_out       <= cur.point;
      data_milli      <= cur.data;
      event_kind      <= code[5:4];
      event_state     <= code[3:0];
      to_alarm_list   <= code[5:4] != alm_pkg::KIND_NORMAL;
      status_fail     <= cur.fail;
      status_force    <= cur.frc;
      status_overflow <= cur.ovf;
      last_message    <= last;
    end
  end

  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.ev.n != '0 && cur.ev.n <= alm_pkg::MsgCntW'(alm_pkg::MaxMsg)))
    else $error("scan record with bad message count");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx < cur.ev.n)
    else $error("message index past end of record");

endmodule

// ----- sv/analog_limit_alarm_monitor.sv -----
// Channel   Direction  Handshake             Transaction
// scan      in         push / full           one analog scan (point, value, ref, flags)
// message   out        empty / pop           one fault, force, change or limit message
// config    in         wr_en / wr_index      one register write of wr_data
//
// The front takes one scan per cycle while full is low and decides its messages
// (0 to 6) in the next cycle; these pass through a 4-deep record queue and the
// back's current record register to the output registers, then leave one per
// cycle while pop is high, so the message port is the only serial point. rst is
// synchronous: limits go to their widest settings, state to first scan. full
// rises only when the queue is full and a classified scan waits to enter it.
module analog_limit_alarm_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [alm_pkg::PointW-1:0]        point_num,
  input  logic signed [alm_pkg::ValW-1:0]   value_milli,
  input  logic signed [alm_pkg::ValW-1:0]   reference_milli,
  input  logic                              chan_fault,
  input  logic                              forced,
  input  logic                              out_of_range,
  output logic                              empty,
  input  logic                              pop,
  output logic [alm_pkg::PointW-1:0]        point_out,
  output logic signed [alm_pkg::ValW-1:0]   data_milli,
  output logic [1:0]                        event_kind,
  output logic [3:0]                        event_state,
  output logic                              to_alarm_list,
  output logic                              status_fail,
  output logic                              status_force,
  output logic                              status_overflow,
  output logic                              last_message,
  input  logic                              wr_en,
  input  logic [alm_pkg::RegIdxW-1:0]       wr_index,
  input  logic [alm_pkg::ValW-1:0]          wr_data
);

  alm_pkg::rec_t q_in, q_out;
  logic          q_push, q_full, q_pop, q_empty;

  alm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .point_num       (point_num),
    .value_milli     (value_milli),
    .reference_milli (reference_milli),
    .chan_fault      (chan_fault),
    .forced          (forced),
    .out_of_range    (out_of_range),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_rec           (q_in)
  );

  alm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_in),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_out)
  );

  alm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_rec           (q_out),
    .empty           (empty),
    .pop             (pop),
    .point_out       (point_out),
    .data_milli      (data_milli),
    .event_kind      (event_kind),
    .event_state     (event_state),
    .to_alarm_list   (to_alarm_list),
    .status_fail     (status_fail),
    .status_force    (status_force),
    .status_overflow (status_overflow),
    .last_message    (last_message)
  );

endmodule
